// ----- hdl/cut_tree_packet_classifier_lookup_macros.svh -----
// Assertion macros shared by the checker of the cut tree classifier.
// Holds macro definitions only; no other file content.
`ifndef CUT_TREE_PACKET_CLASSIFIER_LOOKUP_MACROS_SVH
`define CUT_TREE_PACKET_CLASSIFIER_LOOKUP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/ctc_pkg.sv -----
// Package of the cut tree classifier: request and response types, sizes and codes.
// Used by the top level and the checker; depends on nothing.
package ctc_pkg;
	localparam int NODE_W = 10;
	localparam int RULE_W = 10;
	localparam int SLOT_W = 6;
	localparam int LEAF_W = 5;
	localparam int DIM_W = 3;
	localparam int DIMENSIONS = 6;
	localparam int MAX_DEPTH = 64;
	localparam int DEPTH_W = 7;

	localparam logic [2:0] OP_NODE = 3'd0;
	localparam logic [2:0] OP_CHILD = 3'd1;
	localparam logic [2:0] OP_LEAF = 3'd2;
	localparam logic [2:0] OP_BOUND = 3'd3;
	localparam logic [2:0] OP_LOOKUP = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HIT = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [9:0] table_index;
		logic [5:0] slot;
		logic [31:0] value_a;
		logic [31:0] value_b;
		logic [31:0] key_src_addr;
		logic [31:0] key_dst_addr;
		logic [15:0] key_src_port;
		logic [15:0] key_dst_port;
		logic [7:0] key_protocol;
		logic [15:0] key_extra;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] matched_rule;
	} rsp_t;

	// Width of each header dimension in bits.
	function automatic logic [5:0] key_width(input logic [DIM_W-1:0] d);
		case (d)
			3'd0, 3'd1: key_width = 6'd32;
			3'd2, 3'd3, 3'd5: key_width = 6'd16;
			3'd4: key_width = 6'd8;
			default: key_width = 6'd0;
		endcase
	endfunction
endpackage

// ----- hdl/ctc_rule_check.sv -----
// Range comparator for one rule dimension, shared by every bound check of a leaf scan.
// Depends on nothing.
module ctc_rule_check (
	input logic [31:0] low,
	input logic [31:0] high,
	input logic [31:0] key,
	output logic covers
);
	assign covers = (low <= key) && (high >= key);
endmodule

// ----- hdl/cut_tree_packet_classifier_lookup.sv -----
// Top level of the cut tree packet classifier: tables, sequencer and output register.
// Depends on ctc_pkg and ctc_rule_check.
//
// A table write is taken in S_IDLE, and its response is raised from S_DONE. A lookup
// walks the tree with one node read and one child read per level (S_NODE, S_DEC, S_CHILD,
// S_REFW). It then scans the leaf: one reference read per rule (S_REF, S_REFW), then one
// bound read per dimension through the one shared comparator (S_BND, S_CMP). The
// receiver can hold off the response, which then waits in S_DONE.
// The sequencer serves one request at a time; stall is high while it is busy.
module cut_tree_packet_classifier_lookup (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [9:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input ctc_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ctc_pkg::rsp_t out_data
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NODE = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_CHILD = 4'd3;
	localparam logic [3:0] S_REF = 4'd4;
	localparam logic [3:0] S_REFW = 4'd5;
	localparam logic [3:0] S_BND = 4'd6;
	localparam logic [3:0] S_CMP = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [13:0] node_mem [1024];
	logic [10:0] child_mem [65536];
	logic [9:0] ref_mem [32768];
	logic [63:0] bound_mem [6144];

	logic [3:0] state_q;
	logic [9:0] root_q;
	ctc_pkg::req_t req_q;
	ctc_pkg::rsp_t res_q;
	logic [9:0] node_q;
	logic [13:0] node_rd_q;
	logic [10:0] child_rd_q;
	logic [9:0] ref_rd_q;
	logic [63:0] bound_rd_q;
	logic [6:0] depth_q;
	logic [5:0] cur_q [6];
	logic [2:0] dim_q;
	logic [3:0] nbits_q;
	logic [5:0] cslot_q;
	logic [4:0] ri_q;
	logic [5:0] cnt_q;
	logic [9:0] rule_q;
	logic [2:0] cd_q;
	logic [12:0] baddr_q;
	logic busy_q;

	assign in_stall = busy_q;

	// Key of dimension d, zero-extended to 32 bits.
	function automatic logic [31:0] key_of(input ctc_pkg::req_t r, input logic [2:0] d);
		case (d)
			3'd0: key_of = r.key_src_addr;
			3'd1: key_of = r.key_dst_addr;
			3'd2: key_of = {16'd0, r.key_src_port};
			3'd3: key_of = {16'd0, r.key_dst_port};
			3'd4: key_of = {24'd0, r.key_protocol};
			3'd5: key_of = {16'd0, r.key_extra};
			default: key_of = 32'd0;
		endcase
	endfunction

	logic [2:0] hdim;
	logic [3:0] hbits;
	logic [5:0] hcur;
	logic [5:0] hshift;
	logic [31:0] shifted;
	logic [31:0] hmask;
	logic [31:0] hslot;
	logic covers;

	assign hdim = node_rd_q[3:1];
	assign hbits = node_rd_q[7:4];
	assign hcur = (hdim < 3'(ctc_pkg::DIMENSIONS)) ? cur_q[hdim] : 6'd0;
	assign hshift = hcur - {2'd0, hbits};
	assign shifted = key_of(req_q, hdim) >> hshift;
	assign hmask = (32'd1 << hbits) - 32'd1;
	assign hslot = shifted & hmask;

	ctc_rule_check u_check (
		.low(bound_rd_q[31:0]),
		.high(bound_rd_q[63:32]),
		.key(key_of(req_q, cd_q)),
		.covers(covers)
	);

	// Table writes and registered reads.
	always_ff @(posedge clk) begin
		if (in_valid && !busy_q) begin
			case (in_data.op)
				ctc_pkg::OP_NODE: begin
					node_mem[in_data.table_index] <= {
						(in_data.value_b > 32'd63) ? 6'd63 : in_data.value_b[5:0],
						in_data.value_a[7:0]};
				end
				ctc_pkg::OP_CHILD: begin
					child_mem[{in_data.table_index, in_data.slot}] <=
						{in_data.value_b[0], in_data.value_a[9:0]};
				end
				ctc_pkg::OP_LEAF: begin
					if (in_data.slot < 6'd32)
						ref_mem[{in_data.table_index, in_data.slot[4:0]}] <=
							in_data.value_a[9:0];
				end
				ctc_pkg::OP_BOUND: begin
					if (in_data.slot < 6'(ctc_pkg::DIMENSIONS))
						bound_mem[13'(in_data.table_index * 13'd6) + {7'd0, in_data.slot}]
							<= {in_data.value_b, in_data.value_a};
				end
				default: begin
				end
			endcase
		end
		node_rd_q <= node_mem[node_q];
		child_rd_q <= child_mem[{node_q, cslot_q}];
		ref_rd_q <= ref_mem[{node_q, ri_q}];
		bound_rd_q <= bound_mem[baddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			root_q <= 10'd1;
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (cfg_we)
				root_q <= cfg_wdata;
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !busy_q) begin
						req_q <= in_data;
						busy_q <= 1'b1;
						if (in_data.op == ctc_pkg::OP_LOOKUP) begin
							node_q <= root_q;
							depth_q <= '0;
							for (int d = 0; d < 6; d++)
								cur_q[d] <= ctc_pkg::key_width(3'(d));
							state_q <= S_NODE;
						end else begin
							res_q <= '{status: ctc_pkg::ST_OK, matched_rule: 10'd0};
							state_q <= S_DONE;
						end
					end
				end
				S_NODE: state_q <= S_DEC;
				S_DEC: begin
					if (node_rd_q[0]) begin
						cnt_q <= (node_rd_q[13:8] > 6'd32) ? 6'd32 : node_rd_q[13:8];
						ri_q <= '0;
						state_q <= S_REF;
					end else if (depth_q >= 7'(ctc_pkg::MAX_DEPTH)
						|| hdim >= 3'(ctc_pkg::DIMENSIONS)
						|| {2'd0, hbits} > hcur || hslot >= 32'd64) begin
						res_q <= '{status: ctc_pkg::ST_MISS, matched_rule: 10'd0};
						state_q <= S_DONE;
					end else begin
						cslot_q <= hslot[5:0];
						dim_q <= hdim;
						nbits_q <= hbits;
						state_q <= S_CHILD;
					end
				end
				S_CHILD: begin
					// The child read is issued this cycle; its data is used in S_REFW.
					state_q <= S_REFW;
					ri_q <= ri_q;
				end
				S_REFW: begin
					if (cnt_q == 6'd0 && !node_rd_q[0]) begin
						if (!child_rd_q[10]) begin
							res_q <= '{status: ctc_pkg::ST_MISS, matched_rule: 10'd0};
							state_q <= S_DONE;
						end else begin
							node_q <= child_rd_q[9:0];
							cur_q[dim_q] <= cur_q[dim_q] - {2'd0, nbits_q};
							depth_q <= depth_q + 7'd1;
							state_q <= S_NODE;
						end
					end else begin
						rule_q <= ref_rd_q;
						cd_q <= '0;
						baddr_q <= 13'(ref_rd_q * 13'd6);
						state_q <= S_BND;
					end
				end
				S_REF: begin
					if ({1'b0, ri_q} >= cnt_q) begin
						res_q <= '{status: ctc_pkg::ST_MISS, matched_rule: 10'd0};
						state_q <= S_DONE;
					end else begin
						state_q <= S_REFW;
					end
				end
				S_BND: state_q <= S_CMP;
				S_CMP: begin
					if (!covers) begin
						ri_q <= ri_q + 5'd1;
						if (ri_q == 5'd31) begin
							res_q <= '{status: ctc_pkg::ST_MISS, matched_rule: 10'd0};
							state_q <= S_DONE;
						end else
							state_q <= S_REF;
					end else if (cd_q == 3'(ctc_pkg::DIMENSIONS - 1)) begin
						res_q <= '{status: ctc_pkg::ST_HIT, matched_rule: rule_q};
						state_q <= S_DONE;
					end else begin
						cd_q <= cd_q + 3'd1;
						baddr_q <= baddr_q + 13'd1;
						state_q <= S_BND;
					end
				end
				S_DONE: begin
					// The response only moves to the port once the previous one has gone.
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_data <= res_q;
						busy_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A new node read clears the leaf count so S_REFW knows it follows a child read.
			if (state_q == S_DEC && !node_rd_q[0])
				cnt_q <= 6'd0;
		end
	end
endmodule

// ----- hdl/ctc_checker.sv -----
// Port checker for the cut tree classifier, bound to the top level.
// Depends on ctc_pkg and the assertion macro header.
`include "cut_tree_packet_classifier_lookup_macros.svh"
module ctc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ctc_pkg::rsp_t out_data
);
	`CTC_ASSERT_IMPL(a_status, clk, arst_n, out_valid, out_data.status != 2'd3, "bad status")
	`CTC_ASSERT_IMPL(a_miss0, clk, arst_n, out_valid && out_data.status != ctc_pkg::ST_HIT, out_data.matched_rule == 10'd0, "rule on miss")
	`CTC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "response dropped")
	`CTC_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "request taken while busy")
endmodule

bind cut_tree_packet_classifier_lookup ctc_checker u_ctc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
